@@ rtl/pps_pkg.sv @@
package pps_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    localparam logic       REQ_ARRIVAL = 1'b0;
    localparam logic       REQ_TICK    = 1'b1;

    localparam logic [2:0] EV_ACCEPT   = 3'd0;
    localparam logic [2:0] EV_PREEMPT  = 3'd1;
    localparam logic [2:0] EV_REJECT   = 3'd2;
    localparam logic [2:0] EV_RAN      = 3'd3;
    localparam logic [2:0] EV_DONE     = 3'd4;
    localparam logic [2:0] EV_IDLE     = 3'd5;

    localparam logic [7:0] QUANTUM_RST = 8'd2;
    localparam logic [7:0] SLICE_MAX   = 8'd255;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  job_id;
        logic [7:0]  job_priority;
        logic [15:0] job_run_time;
    } t_req;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  event_job;
        logic [15:0] turnaround;
        logic [15:0] event_time;
        logic        last_of_run;
    } t_evt;

    typedef struct packed {
        logic [7:0]  job;
        logic [7:0]  pri;
        logic [15:0] rem;
        logic [7:0]  slice;
        logic [15:0] arr;
        logic [15:0] order;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ rtl/preemptive_priority_scheduler.sv @@
// A result is registered after a scan (ST_SCAN) of the job table, a RAM with separate read and
// write ports, then a decision state (ST_POST).
// A tick rescans after a retirement and after a rotation.
// One item at a time: the next transfer in waits until the last one, with any rescans, is done;
// output stalls hold it longer.
// Synchronous active-low reset clears valid bits, time, order counter, quantum = 2.
module preemptive_priority_scheduler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pps_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pps_pkg::t_evt o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;

    localparam logic [1:0] K_ARR = 2'd0;
    localparam logic [1:0] K_T0  = 2'd1;
    localparam logic [1:0] K_T1  = 2'd2;
    localparam logic [1:0] K_T2  = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  r_kind;
    pps_pkg::t_req               r_req;
    logic [pps_pkg::MAX_JOBS-1:0] r_valid;
    logic [15:0]                 r_time;
    logic [15:0]                 r_oc;
    logic [7:0]                  r_quantum;
    logic [pps_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_pv;
    logic [pps_pkg::IDX_W-1:0]   r_pidx;
    logic                        r_found;
    logic                        r_tie;
    logic [pps_pkg::IDX_W-1:0]   r_bidx;
    pps_pkg::t_entry             r_best;
    logic [15:0]                 r_bage;
    logic                        r_ov;
    pps_pkg::t_evt               r_out;

    logic                        ram_we;
    logic [pps_pkg::IDX_W-1:0]   ram_waddr;
    pps_pkg::t_entry             ram_wdata;
    pps_pkg::t_entry             ram_rdata;
    logic [pps_pkg::ENTRY_W-1:0] ram_rraw;

    logic                        scan_more;
    logic [15:0]                 cand_age;
    logic                        better;
    logic                        room;
    logic                        retire_c;
    logic                        rotate_c;
    logic                        run_c;
    logic                        fire;
    logic                        slot_found;
    logic [pps_pkg::IDX_W-1:0]   slot;
    pps_pkg::t_evt               evt;

    pps_ram #(
        .WIDTH (pps_pkg::ENTRY_W),
        .DEPTH (pps_pkg::MAX_JOBS),
        .AW    (pps_pkg::IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[pps_pkg::IDX_W-1:0]),
        .o_rdata (ram_rraw)
    );

    assign ram_rdata   = pps_pkg::t_entry'(ram_rraw);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign scan_more = (r_cnt < pps_pkg::CNT_W'(pps_pkg::MAX_JOBS));
    assign cand_age  = r_oc - ram_rdata.order;
    assign better    = !r_found || (ram_rdata.pri < r_best.pri) ||
                       ((ram_rdata.pri == r_best.pri) && (cand_age > r_bage));
    assign room      = !r_ov || !i_out_stall;

    always_comb begin
        slot_found = 1'b0;
        slot       = '0;
        for (int i = pps_pkg::MAX_JOBS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                slot_found = 1'b1;
                slot       = pps_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        retire_c = (r_kind == K_T0) && r_found && (r_best.rem == 16'd0);
        rotate_c = ((r_kind == K_T0) || (r_kind == K_T1)) && !retire_c && r_found &&
                   (r_best.slice >= r_quantum) && r_tie;
        run_c    = (r_kind != K_ARR) && !retire_c && !rotate_c;
        fire     = (r_state == ST_POST) && (rotate_c || room);

        evt             = '0;
        evt.event_time  = r_time;
        evt.last_of_run = 1'b1;
        if (r_kind == K_ARR) begin
            evt.event_job = r_req.job_id;
            if (!slot_found) begin
                evt.event_res = pps_pkg::EV_REJECT;
            end else if (r_found && (r_req.job_priority < r_best.pri)) begin
                evt.event_res = pps_pkg::EV_PREEMPT;
            end else begin
                evt.event_res = pps_pkg::EV_ACCEPT;
            end
        end else if (retire_c) begin
            evt.event_res   = pps_pkg::EV_DONE;
            evt.event_job   = r_best.job;
            evt.turnaround  = r_time - r_best.arr;
            evt.last_of_run = 1'b0;
        end else if (r_found) begin
            evt.event_res = pps_pkg::EV_RAN;
            evt.event_job = r_best.job;
        end else begin
            evt.event_res = pps_pkg::EV_IDLE;
        end

        ram_we    = 1'b0;
        ram_waddr = r_bidx;
        ram_wdata = r_best;
        if (fire) begin
            if (r_kind == K_ARR) begin
                ram_we          = slot_found;
                ram_waddr       = slot;
                ram_wdata.job   = r_req.job_id;
                ram_wdata.pri   = r_req.job_priority;
                ram_wdata.rem   = r_req.job_run_time;
                ram_wdata.slice = '0;
                ram_wdata.arr   = r_time;
                ram_wdata.order = r_oc;
            end else if (rotate_c) begin
                ram_we          = 1'b1;
                ram_wdata.order = r_oc;
                ram_wdata.slice = '0;
            end else if (run_c && r_found) begin
                ram_we = 1'b1;
                if (r_best.rem != 16'd0) begin
                    ram_wdata.rem = r_best.rem - 16'd1;
                end
                if (r_best.slice != pps_pkg::SLICE_MAX) begin
                    ram_wdata.slice = r_best.slice + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_kind    <= K_ARR;
            r_valid   <= '0;
            r_time    <= '0;
            r_oc      <= '0;
            r_quantum <= pps_pkg::QUANTUM_RST;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (fire && !rotate_c) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        r_quantum <= i_cfg_data;
                    end
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_kind  <= (i_in_data.req_type == pps_pkg::REQ_TICK) ? K_T0 : K_ARR;
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                        r_pv    <= 1'b0;
                        r_found <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_pv   <= scan_more && r_valid[r_cnt[pps_pkg::IDX_W-1:0]];
                    r_pidx <= r_cnt[pps_pkg::IDX_W-1:0];
                    if (scan_more) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= ST_POST;
                    end
                    if (r_pv) begin
                        if (!r_found || (ram_rdata.pri < r_best.pri)) begin
                            r_tie <= 1'b0;
                        end else if (ram_rdata.pri == r_best.pri) begin
                            r_tie <= 1'b1;
                        end
                        if (better) begin
                            r_found <= 1'b1;
                            r_best  <= ram_rdata;
                            r_bidx  <= r_pidx;
                            r_bage  <= cand_age;
                        end
                    end
                end
                ST_POST: begin
                    if (fire) begin
                        if (!rotate_c) begin
                            r_out <= evt;
                        end
                        if (r_kind == K_ARR) begin
                            if (slot_found) begin
                                r_valid[slot] <= 1'b1;
                                r_oc          <= r_oc + 16'd1;
                            end
                            r_state <= ST_IDLE;
                        end else if (retire_c || rotate_c) begin
                            if (retire_c) begin
                                r_valid[r_bidx] <= 1'b0;
                                r_kind          <= K_T1;
                            end else begin
                                r_oc   <= r_oc + 16'd1;
                                r_kind <= K_T2;
                            end
                            r_state <= ST_SCAN;
                            r_cnt   <= '0;
                            r_pv    <= 1'b0;
                            r_found <= 1'b0;
                        end else begin
                            r_time  <= r_time + 16'd1;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/pps_ram.sv @@
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
